// ===== sv/pat_pkg.sv =====
package pat_pkg;

	// external opcode codes
	localparam logic [2:0] OPC_INSERT  = 3'd0;
	localparam logic [2:0] OPC_DEL_VAL = 3'd1;
	localparam logic [2:0] OPC_DEL_POS = 3'd2;
	localparam logic [2:0] OPC_FIND    = 3'd3;
	localparam logic [2:0] OPC_READ    = 3'd4;
	localparam logic [2:0] OPC_CLEAR   = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_DEL_VAL,
		OP_DEL_POS,
		OP_FIND,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_e;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_CMP,
		BS_EXEC
	} bst_e;

	typedef struct packed {
		logic        [2:0]  opcode;
		logic signed [31:0] value;
		logic        [4:0]  position;
	} in_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic        [3:0]  index;
		logic signed [31:0] data;
		logic        [4:0]  fill;
	} out_t;

	// classified command as it sits in the queue
	typedef struct packed {
		op_e                op;
		logic signed [31:0] value;
		logic        [4:0]  position;
		logic               ins_bad;
	} cmd_t;

endpackage

// ===== sv/positional_array_table.sv =====
// positional array table: packed table of signed words with a fill count
// each transaction takes a compare step and then an execute step over the cell row in the
// back end; the two-entry queue accepts new transactions meanwhile until it is full
// done rises once the execute step has registered the result
// reset: arst_n clears the queue, the table cells and the count; done is low
// the result is shown for one cycle on done and cannot be held off
module positional_array_table import pat_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  cmd,
	output logic done,
	output out_t result
);

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head;

	// front end: accept the transaction and decode the opcode and insert range
	pat_front #(
		.DEPTH(DEPTH)
	) u_front (
		.start    (start),
		.cmd      (cmd),
		.q_full   (q_full),
		.busy     (busy),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// two-entry queue decouples acceptance from execution
	pat_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// back end: parallel compare across the cells, then shift/update and report
	pat_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== sv/pat_front.sv =====
module pat_front import pat_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic start,
	input  in_t  cmd,
	input  logic q_full,
	output logic busy,
	output logic push,
	output cmd_t push_cmd
);

	localparam int XW = ($clog2(DEPTH + 1) > 5) ? $clog2(DEPTH + 1) : 5;

	assign busy = q_full;
	assign push = start && !q_full;

	always_comb begin
		push_cmd.value    = cmd.value;
		push_cmd.position = cmd.position;
		// insert slot must be 1..DEPTH, checked before fullness
		push_cmd.ins_bad  = (cmd.position == 5'd0) || (XW'(cmd.position) > XW'(DEPTH));
		case (cmd.opcode)
			OPC_INSERT:  push_cmd.op = OP_INSERT;
			OPC_DEL_VAL: push_cmd.op = OP_DEL_VAL;
			OPC_DEL_POS: push_cmd.op = OP_DEL_POS;
			OPC_FIND:    push_cmd.op = OP_FIND;
			OPC_READ:    push_cmd.op = OP_READ;
			OPC_CLEAR:   push_cmd.op = OP_CLEAR;
			default:     push_cmd.op = OP_NOP;
		endcase
	end

endmodule

// ===== sv/pat_queue.sv =====
module pat_queue import pat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/pat_back.sv =====
module pat_back import pat_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic q_empty,
	output logic pop,
	output logic done,
	output out_t result
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int XW = (CW > 5) ? CW : 5;

	bst_e               st_q, st_d;
	cmd_t               cmd_q;
	logic [DEPTH-1:0]   match_s1, match_d;
	logic signed [31:0] rd_s1, rd_d;
	logic signed [31:0] entries_q [DEPTH];
	logic signed [31:0] entries_d [DEPTH];
	logic [CW-1:0]      count_q, count_d;
	logic               done_q;
	out_t               result_q, result_d;
	logic               exec;
	logic [IW-1:0]      hit_idx;
	logic               hit;
	logic [XW-1:0]      pos_x, cnt_x, slot_x;

	// next state
	always_comb begin
		case (st_q)
			BS_IDLE: st_d = q_empty ? BS_IDLE : BS_CMP;
			BS_CMP:  st_d = BS_EXEC;
			BS_EXEC: st_d = q_empty ? BS_IDLE : BS_CMP;
			default: st_d = BS_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		case (st_q)
			BS_IDLE: begin
				pop  = !q_empty;
				exec = 1'b0;
			end
			BS_CMP: begin
				pop  = 1'b0;
				exec = 1'b0;
			end
			BS_EXEC: begin
				pop  = !q_empty;
				exec = 1'b1;
			end
			default: begin
				pop  = 1'b0;
				exec = 1'b0;
			end
		endcase
	end

	assign pos_x = XW'(cmd_q.position);
	assign cnt_x = XW'(count_q);

	// compare stage: match every live cell, pick the addressed cell
	always_comb begin
		rd_d = '0;
		for (int k = 0; k < DEPTH; k++) begin
			match_d[k] = (entries_q[k] == cmd_q.value) && (XW'(k) < cnt_x);
			if (XW'(k + 1) == pos_x) begin
				rd_d = entries_q[k];
			end
		end
	end

	// first match wins
	always_comb begin
		hit_idx = '0;
		for (int k = DEPTH - 1; k >= 0; k--) begin
			if (match_s1[k]) begin
				hit_idx = IW'(k);
			end
		end
	end
	assign hit = |match_s1;

	assign slot_x = (cmd_q.op == OP_DEL_VAL) ? XW'(hit_idx) : (pos_x - XW'(1));

	// execute stage
	always_comb begin
		entries_d = entries_q;
		count_d   = count_q;
		result_d  = '0;
		result_d.status = ST_OK;
		case (cmd_q.op)
			OP_INSERT: begin
				if (cmd_q.ins_bad) begin
					result_d.status = ST_RANGE;
				end else if (cnt_x >= XW'(DEPTH)) begin
					result_d.status = ST_FULL;
				end else begin
					// slots above the insert point move up; past the end nothing moves
					for (int k = 0; k < DEPTH; k++) begin
						if (XW'(k) == pos_x - XW'(1)) begin
							entries_d[k] = cmd_q.value;
						end else if (k > 0 && XW'(k) > pos_x - XW'(1) && XW'(k) <= cnt_x) begin
							entries_d[k] = entries_q[(k > 0) ? k - 1 : 0];
						end
					end
					count_d = (pos_x > cnt_x) ? CW'(pos_x) : count_q + CW'(1);
				end
			end
			OP_DEL_VAL, OP_DEL_POS: begin
				if (cmd_q.op == OP_DEL_VAL && !hit) begin
					result_d.status = ST_MISS;
				end else if (cmd_q.op == OP_DEL_POS &&
						(pos_x == XW'(0) || pos_x > cnt_x)) begin
					result_d.status = ST_RANGE;
				end else begin
					// cells at and above count already hold zero
					for (int k = 0; k < DEPTH; k++) begin
						if (XW'(k) >= slot_x) begin
							entries_d[k] = (k + 1 < DEPTH) ? entries_q[(k + 1 < DEPTH) ? k + 1 : k]
								: '0;
						end
					end
					count_d = count_q - CW'(1);
				end
			end
			OP_FIND: begin
				if (!hit) begin
					result_d.status = ST_MISS;
				end else begin
					result_d.index = 4'(hit_idx);
				end
			end
			OP_READ: begin
				if (pos_x == XW'(0) || pos_x > cnt_x) begin
					result_d.status = ST_RANGE;
				end else begin
					result_d.data = rd_s1;
				end
			end
			OP_CLEAR: begin
				for (int k = 0; k < DEPTH; k++) begin
					entries_d[k] = '0;
				end
				count_d = '0;
			end
			default: begin
			end
		endcase
		result_d.fill = 5'(count_d);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (st_q == BS_CMP) begin
			match_s1 <= match_d;
			rd_s1    <= rd_d;
		end
		if (exec) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= BS_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			for (int k = 0; k < DEPTH; k++) begin
				entries_q[k] <= '0;
			end
		end else begin
			st_q   <= st_d;
			done_q <= exec;
			if (exec) begin
				count_q   <= count_d;
				entries_q <= entries_d;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
